// ===== hdl/sqd_pkg.sv =====
// Shared types and constants for the stereo quantizer with dither.
// LCG coefficients, fixed-point widths and register indexes.
// No dependencies.
package sqd_pkg;

  // Fixed-point format of the incoming samples
  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 48;
  localparam int OUT_W     = 24;
  localparam int LCG_W     = 31;
  localparam int DITH_W    = 16;

  // Sum of sample and dither, and the rounded integer part
  localparam int SUM_W = SAMPLE_W + 1;
  localparam int Q_W   = SUM_W - FRAC_BITS + 1;

  // Dither realignment from 16 fractional bits to FRAC_BITS
  localparam int DITH_SHL = (FRAC_BITS >= DITH_W) ? FRAC_BITS - DITH_W : 0;
  localparam int DITH_SHR = (FRAC_BITS >= DITH_W) ? 0 : DITH_W - FRAC_BITS;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]    pcm_t;
  typedef logic [LCG_W-1:0]           lcg_t;
  typedef logic [DITH_W-1:0]          dith_t;
  typedef logic [1:0]                 cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_WIDTH_MODE = 2'd0;
  localparam cfg_idx_t CFG_DITHER_EN  = 2'd1;

  // LCG: g = (g * MUL + ADD) mod 2^31
  localparam logic [63:0] LCG_MUL64  = 64'd1103515245;
  localparam logic [63:0] LCG_ADD64  = 64'd12345;
  localparam logic [63:0] LCG_MASK64 = 64'h7fffffff;
  localparam lcg_t        LCG_SEED   = 31'h16BA2118;

  localparam lcg_t LCG_MUL = LCG_W'(LCG_MUL64 & LCG_MASK64);
  localparam lcg_t LCG_ADD = LCG_W'(LCG_ADD64 & LCG_MASK64);

  // Two steps folded into one: g2 = MUL^2 * g + (MUL + 1) * ADD
  localparam lcg_t LCG_MUL2 = LCG_W'((LCG_MUL64 * LCG_MUL64) & LCG_MASK64);
  localparam lcg_t LCG_ADD2 = LCG_W'(((LCG_MUL64 + 64'd1) * LCG_ADD64) & LCG_MASK64);

  // Generator values for the first frame after reset
  localparam lcg_t NEXT_L_RST =
    LCG_W'((LCG_MUL64 * 64'(LCG_SEED) + LCG_ADD64) & LCG_MASK64);
  localparam lcg_t NEXT_R_RST =
    LCG_W'((64'(LCG_MUL2) * 64'(LCG_SEED) + 64'(LCG_ADD2)) & LCG_MASK64);

  // Saturation bounds on the rounded integer
  localparam logic signed [Q_W-1:0] Q_HI16 = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_LO16 = Q_W'(-32768);
  localparam logic signed [Q_W-1:0] Q_HI24 = Q_W'(8388607);
  localparam logic signed [Q_W-1:0] Q_LO24 = Q_W'(-8388608);

  // Rounding midpoint of the fractional part
  localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

endpackage

// ===== hdl/sqd_in_if.sv =====
// Input word channel of the stereo quantizer: one stereo frame per word.
// Depends on sqd_pkg.
interface sqd_in_if;
  import sqd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;
  logic    last_frame;

  modport source (output valid, left_sample, right_sample, last_frame, input ready);
  modport sink   (input valid, left_sample, right_sample, last_frame, output ready);

endinterface

// ===== hdl/sqd_out_if.sv =====
// Result word channel of the stereo quantizer: quantized frame and clip flags.
// Depends on sqd_pkg.
interface sqd_out_if;
  import sqd_pkg::*;

  logic valid;
  logic ready;
  pcm_t left_out;
  pcm_t right_out;
  logic left_clipped;
  logic right_clipped;
  logic last_out;

  modport source (output valid, left_out, right_out, left_clipped, right_clipped,
                  last_out, input ready);
  modport sink   (input valid, left_out, right_out, left_clipped, right_clipped,
                  last_out, output ready);

endinterface

// ===== hdl/sqd_cfg_if.sv =====
// Configuration write channel of the stereo quantizer.
// Depends on sqd_pkg.
interface sqd_cfg_if;
  import sqd_pkg::*;

  logic     valid;
  logic     ready;
  cfg_idx_t index;
  logic     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);

endinterface

// ===== hdl/stereo_quantizer_with_dither_unit.sv =====
// Stereo quantizer with rectangular LCG dither, 16- or 24-bit output.
//
// Channels: in_ch takes one stereo frame per word (48-bit signed left and
// right with FRAC_BITS fractional bits, plus a last-frame flag). out_ch
// delivers one word per frame: rounded (ties to even), saturated left and
// right, their clip flags and the copied last flag. cfg_ch writes the width
// mode (index 0) and dither enable (index 1); it is always ready and must be
// used only while no frame is in flight.
// Path: an accepted frame passes the input register and then the result
// register, which drives out_ch.valid and holds the word until it leaves.
// Throughput: one frame per cycle while out_ch takes words; the two LCG
// steps per frame are folded into two parallel constant multiplies that
// precompute the next frame's dither values.
// Stall: when out_ch is not ready the result register holds, the input
// register still takes one more frame, and in_ch.ready drops only when both
// are full.
// Reset (synchronous, rst_n low): pipeline emptied, width mode 16 bit,
// dither on, generator reloaded with the first two values after its seed.
// Depends on sqd_pkg, sqd_in_if, sqd_out_if, sqd_cfg_if.
module stereo_quantizer_with_dither_unit (
  input  logic      clk,
  input  logic      rst_n,
  sqd_in_if.sink    in_ch,
  sqd_out_if.source out_ch,
  sqd_cfg_if.sink   cfg_ch
);
  import sqd_pkg::*;

  typedef struct packed {
    pcm_t value;
    logic clip;
  } quant_t;

  // Configuration registers
  logic width_mode_r;
  logic dither_en_r;

  // Generator values for the next frame's left and right samples
  lcg_t next_l_r, next_l_nxt;
  lcg_t next_r_r, next_r_nxt;

  // Input register
  logic    s1_valid_r;
  sample_t s1_left_r;
  sample_t s1_right_r;
  dith_t   s1_dl_r;
  dith_t   s1_dr_r;
  logic    s1_last_r;

  // Result register
  logic out_valid_r;
  pcm_t left_out_r;
  pcm_t right_out_r;
  logic left_clip_r;
  logic right_clip_r;
  logic last_r;

  logic   in_acc;
  logic   out_free;
  logic   s1_adv;
  quant_t q_left;
  quant_t q_right;

  // Realign a 16-bit dither fraction to FRAC_BITS fractional bits
  function automatic logic [SUM_W-1:0] dith_scale(input dith_t d);
    return (SUM_W'(d) << DITH_SHL) >> DITH_SHR;
  endfunction

  // Add dither, round to nearest with ties to even, saturate
  function automatic quant_t quantize(input sample_t smp, input dith_t d,
                                      input logic wide);
    logic signed [SUM_W-1:0] sum;
    logic signed [Q_W-1:0]   q_floor;
    logic signed [Q_W-1:0]   q_rnd;
    logic signed [Q_W-1:0]   hi;
    logic signed [Q_W-1:0]   lo;
    logic [FRAC_BITS-1:0]    frac;
    logic                    up;
    quant_t                  res;
    sum     = SUM_W'(smp) + $signed(dith_scale(d));
    q_floor = Q_W'(sum >>> FRAC_BITS);
    frac    = sum[FRAC_BITS-1:0];
    up      = (frac > FRAC_HALF) || ((frac == FRAC_HALF) && q_floor[0]);
    q_rnd   = q_floor + $signed(Q_W'(up));
    hi      = wide ? Q_HI24 : Q_HI16;
    lo      = wide ? Q_LO24 : Q_LO16;
    if (q_rnd > hi) begin
      res.value = hi[OUT_W-1:0];
      res.clip  = 1'b1;
    end else if (q_rnd < lo) begin
      res.value = lo[OUT_W-1:0];
      res.clip  = 1'b1;
    end else begin
      res.value = q_rnd[OUT_W-1:0];
      res.clip  = 1'b0;
    end
    return res;
  endfunction

  // Handshake: advance the input register whenever the result slot frees
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Step the generator two places from the last right value
  assign next_l_nxt = next_r_r * LCG_MUL + LCG_ADD;
  assign next_r_nxt = next_r_r * LCG_MUL2 + LCG_ADD2;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= 1'b0;
      dither_en_r  <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_WIDTH_MODE: width_mode_r <= cfg_ch.data;
        CFG_DITHER_EN:  dither_en_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Advance the generator only for dithered frames
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_l_r <= NEXT_L_RST;
      next_r_r <= NEXT_R_RST;
    end else if (in_acc && dither_en_r) begin
      next_l_r <= next_l_nxt;
      next_r_r <= next_r_nxt;
    end
  end

  // Input register: capture the frame and its dither fractions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_left_r  <= in_ch.left_sample;
      s1_right_r <= in_ch.right_sample;
      s1_last_r  <= in_ch.last_frame;
      s1_dl_r    <= dither_en_r ? next_l_r[LCG_W-1 -: DITH_W] : '0;
      s1_dr_r    <= dither_en_r ? next_r_r[LCG_W-1 -: DITH_W] : '0;
    end
  end

  // Quantize both channels
  assign q_left  = quantize(s1_left_r,  s1_dl_r, width_mode_r);
  assign q_right = quantize(s1_right_r, s1_dr_r, width_mode_r);

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_out_r   <= q_left.value;
      right_out_r  <= q_right.value;
      left_clip_r  <= q_left.clip;
      right_clip_r <= q_right.clip;
      last_r       <= s1_last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_out      = left_out_r;
  assign out_ch.right_out     = right_out_r;
  assign out_ch.left_clipped  = left_clip_r;
  assign out_ch.right_clipped = right_clip_r;
  assign out_ch.last_out      = last_r;

`ifndef SYNTHESIS
  // A clipped value sits on one of the saturation bounds
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && left_clip_r) |->
      (left_out_r == 24'h7fffff || left_out_r == 24'h800000 ||
       left_out_r == 24'h007fff || left_out_r == 24'hff8000))
    else $error("left clip flag set but value is not a bound");

  // Both stages full and stalled: take no new word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while pipeline is full and stalled");

  // A result appears only after a frame sat in the input register
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result valid without a frame in the input register");

  // A dithered frame always moves the generator (the LCG has no fixed point)
  a_lcg_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && dither_en_r) |=> (next_l_r != $past(next_l_r)))
    else $error("generator did not advance on a dithered frame");

  // Without a dithered frame the generator holds
  a_lcg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && dither_en_r) |=> ($stable(next_l_r) && $stable(next_r_r)))
    else $error("generator moved without a dithered frame");
`endif

endmodule

// ===== bench/sqd_checker.sv =====
// Result checker for the stereo quantizer: watches the three word channels,
// predicts each quantized frame and compares it with what the block delivers.
// Depends on sqd_pkg, sqd_in_if, sqd_out_if and sqd_cfg_if.
`timescale 1ns / 1ps

module sqd_checker (
  input  logic clk,
  input  logic rst_n,
  sqd_in_if    in_ch,
  sqd_out_if   out_ch,
  sqd_cfg_if   cfg_ch,
  output int   n_fail,
  output int   n_pending
);
  import sqd_pkg::*;

  typedef struct {
    pcm_t left;
    pcm_t right;
    logic left_clip;
    logic right_clip;
    logic last;
  } pcm_frame_t;

  localparam longint FRAC_MASK = (longint'(1) << FRAC_BITS) - 1;
  localparam longint FRAC_MID  = longint'(1) << (FRAC_BITS - 1);

  // Predictor state: generator and the two register copies
  pcm_frame_t frames_due[$];
  lcg_t       dither_gen;
  logic       wide_mode;
  logic       dither_on;

  // Advance the generator by one step, mod 2^31
  function automatic lcg_t lcg_step(lcg_t g);
    return lcg_t'(g * LCG_MUL + LCG_ADD);
  endfunction

  // Top 16 generator bits as a fraction, realigned to FRAC_BITS
  function automatic longint dither_frac(lcg_t g);
    longint d;
    d = longint'(g[LCG_W-1 -: DITH_W]);
    return (d << DITH_SHL) >> DITH_SHR;
  endfunction

  // Round to nearest, ties to even, then clamp to the selected range
  task automatic round_saturate(input longint v, input logic wide,
                                output pcm_t q, output logic clip);
    longint ip;
    longint fr;
    longint hi;
    longint lo;
    ip = v >>> FRAC_BITS;
    fr = v & FRAC_MASK;
    hi = wide ? 64'sd8388607 : 64'sd32767;
    lo = wide ? -64'sd8388608 : -64'sd32768;
    if (fr > FRAC_MID || (fr == FRAC_MID && ip[0])) begin
      ip = ip + 1;
    end
    clip = 1'b0;
    if (ip > hi) begin
      ip = hi;
      clip = 1'b1;
    end
    if (ip < lo) begin
      ip = lo;
      clip = 1'b1;
    end
    q = pcm_t'(ip);
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      n_fail = n_fail + 1;
    end
  endtask

  always @(posedge clk) begin
    pcm_frame_t want;
    pcm_frame_t pred;
    longint     l;
    longint     r;
    if (!rst_n) begin
      frames_due.delete();
      dither_gen = LCG_SEED;
      wide_mode  = 1'b0;
      dither_on  = 1'b1;
      n_fail     = 0;
    end else begin
      // Compare a delivered word with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (frames_due.size() == 0) begin
          $error("result word with no frame outstanding");
          n_fail = n_fail + 1;
        end else begin
          want = frames_due.pop_front();
          check_field("left_out", want.left, out_ch.left_out);
          check_field("right_out", want.right, out_ch.right_out);
          check_field("left_clipped", OUT_W'(want.left_clip), OUT_W'(out_ch.left_clipped));
          check_field("right_clipped", OUT_W'(want.right_clip),
                      OUT_W'(out_ch.right_clipped));
          check_field("last_out", OUT_W'(want.last), OUT_W'(out_ch.last_out));
        end
      end

      // Predict the result of an accepted frame; left steps the generator first
      if (in_ch.valid && in_ch.ready) begin
        l = longint'(in_ch.left_sample);
        r = longint'(in_ch.right_sample);
        if (dither_on) begin
          dither_gen = lcg_step(dither_gen);
          l = l + dither_frac(dither_gen);
          dither_gen = lcg_step(dither_gen);
          r = r + dither_frac(dither_gen);
        end
        round_saturate(l, wide_mode, pred.left, pred.left_clip);
        round_saturate(r, wide_mode, pred.right, pred.right_clip);
        pred.last = in_ch.last_frame;
        frames_due.push_back(pred);
      end

      // Track register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_WIDTH_MODE: begin
            wide_mode = cfg_ch.data;
          end
          CFG_DITHER_EN: begin
            dither_on = cfg_ch.data;
          end
          default: begin
          end
        endcase
      end
    end
    n_pending = frames_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the stereo quantizer bench: clock, reset, frame and register stimulus,
// random stalls on the result side, watchdog and the final verdict.
// Depends on sqd_pkg, the channel interfaces, the block and sqd_checker.
`timescale 1ns / 1ps

module tb_top;
  import sqd_pkg::*;

  localparam int     STALL_LIMIT = 4000;
  localparam int     PHASE_WORDS = 425;
  localparam longint HALF        = longint'(1) << (FRAC_BITS - 1);
  localparam longint FMAX        = (longint'(1) << FRAC_BITS) - 1;
  localparam sample_t SMAX       = sample_t'(48'h7FFF_FFFF_FFFF);
  localparam sample_t SMIN       = sample_t'(48'h8000_0000_0000);

  logic clk = 1'b0;
  logic rst_n;
  int   n_fail;
  int   n_pending;
  int   idle_cycles;
  int   calm_words;
  logic wide_now;

  sqd_in_if  in_ch ();
  sqd_out_if out_ch ();
  sqd_cfg_if cfg_ch ();

  stereo_quantizer_with_dither_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sqd_checker i_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed-point sample from an integer part and a raw fraction
  function automatic sample_t fx(longint ip, longint fr);
    return sample_t'((ip <<< FRAC_BITS) + fr);
  endfunction

  // Random sample: full range, the mode's range, clip edges, ties and extremes
  function automatic sample_t rand_sample(logic wide);
    longint      lim;
    longint      ip;
    longint      fr;
    int unsigned sel;
    sample_t     s;
    lim = wide ? 64'sd8388608 : 64'sd32768;
    fr  = longint'({$urandom, $urandom}) & FMAX;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      return sample_t'({$urandom, $urandom});
    end
    if (sel >= 92) begin
      s = $urandom_range(0, 1) ? sample_t'(48'h7FFF_FFFF_FF00) : SMIN;
      return s | sample_t'($urandom_range(0, 255));
    end
    if (sel < 60) begin
      ip = longint'($urandom_range(0, 32'(2 * (lim + 64)))) - (lim + 64);
    end else if (sel < 80) begin
      ip = ($urandom_range(0, 1) ? lim - 1 : -lim) + longint'($urandom_range(0, 6)) - 3;
    end else begin
      ip = longint'($urandom_range(0, 16)) - 8;
    end
    // Bias the fraction toward the rounding points
    if (sel >= 60) begin
      case ($urandom_range(0, 5))
        0: fr = 0;
        1: fr = HALF;
        2: fr = HALF - 1;
        3: fr = HALF + 1;
        4: fr = FMAX;
        default: begin
        end
      endcase
    end
    return fx(ip, fr);
  endfunction

  // Send one frame word after a random gap; hold valid until accepted
  task automatic send_frame(input sample_t l, input sample_t r, input logic last);
    int          gap;
    int unsigned sel;
    gap = 0;
    if (calm_words > 0) begin
      calm_words = calm_words - 1;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 2) begin
        calm_words = $urandom_range(30, 150);
      end else if (sel < 55) begin
        gap = 0;
      end else if (sel < 85) begin
        gap = $urandom_range(1, 3);
      end else if (sel < 97) begin
        gap = $urandom_range(4, 10);
      end else begin
        gap = $urandom_range(20, 40);
      end
    end
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    in_ch.last_frame   <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic drain_frames();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  // Write one register while the block is empty
  task automatic write_reg(input cfg_idx_t idx, input logic value);
    drain_frames();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_WIDTH_MODE) begin
      wide_now = value;
    end
  endtask

  // Result-side backpressure: calm stretches, short and a few long stalls
  initial begin
    int          hold;
    int          calm;
    int unsigned sel;
    out_ch.ready = 1'b0;
    hold = 0;
    calm = 0;
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        calm = calm - 1;
        out_ch.ready <= 1'b1;
      end else if (hold > 0) begin
        hold = hold - 1;
        out_ch.ready <= 1'b0;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
          calm = $urandom_range(40, 200);
          out_ch.ready <= 1'b1;
        end else if (sel < 55) begin
          out_ch.ready <= 1'b1;
        end else begin
          if (sel < 90) begin
            hold = $urandom_range(0, 3);
          end else if (sel < 97) begin
            hold = $urandom_range(4, 12);
          end else begin
            hold = $urandom_range(20, 40);
          end
          out_ch.ready <= 1'b0;
        end
      end
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic mode_seq [4];
    logic dith_seq [4];
    mode_seq = '{1'b1, 1'b0, 1'b1, 1'b0};
    dith_seq = '{1'b1, 1'b0, 1'b0, 1'b1};
    rst_n              = 1'b0;
    calm_words         = 0;
    wide_now           = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    in_ch.last_frame   = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_WIDTH_MODE;
    cfg_ch.data        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: 16-bit range with dither
    send_frame(SMAX, SMIN, 1'b0);
    send_frame(fx(0, 0), fx(-1, FMAX), 1'b1);
    send_frame(fx(32767, 0), fx(-32768, 0), 1'b0);
    send_frame(fx(32767, FMAX), fx(-32769, FMAX), 1'b0);

    // Plain rounding: ties to even, and ties right at the clip edges
    write_reg(CFG_DITHER_EN, 1'b0);
    send_frame(fx(0, HALF), fx(-1, HALF), 1'b0);
    send_frame(fx(1, HALF), fx(-2, HALF), 1'b1);
    send_frame(fx(2, HALF - 1), fx(2, HALF + 1), 1'b0);
    send_frame(fx(32767, HALF), fx(-32769, HALF), 1'b0);
    send_frame(fx(32766, HALF), fx(-32768, HALF), 1'b0);
    send_frame(SMAX, SMIN, 1'b1);

    // 24-bit range, then with dither again
    write_reg(CFG_WIDTH_MODE, 1'b1);
    send_frame(fx(8388607, HALF), fx(-8388609, HALF), 1'b0);
    send_frame(fx(8388606, HALF), fx(-8388608, HALF), 1'b0);
    send_frame(fx(32767, HALF), fx(-32769, HALF), 1'b0);
    send_frame(SMAX, SMIN, 1'b1);
    write_reg(CFG_DITHER_EN, 1'b1);
    send_frame(fx(8388607, 0), fx(-8388609, FMAX), 1'b0);
    send_frame(fx(8388606, FMAX), fx(-8388608, 0), 1'b1);
    send_frame(fx(0, 0), fx(0, FMAX), 1'b0);

    // Random frames under each width and dither combination
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_WIDTH_MODE, mode_seq[p]);
      write_reg(CFG_DITHER_EN, dith_seq[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 0 && i == PHASE_WORDS / 2) begin
          drain_frames();
        end
        send_frame(rand_sample(wide_now), rand_sample(wide_now),
                   $urandom_range(0, 7) == 0);
      end
    end

    drain_frames();
    repeat (8) @(negedge clk);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
